// ===== src/uart_boot_write_memory_host_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bootloader write-memory host
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef UART_BOOT_WRITE_MEMORY_HOST_CORE_DEFINES_SVH
`define UART_BOOT_WRITE_MEMORY_HOST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is applied.
`define UWMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that must also hold during reset.
`define UWMH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UWMH_ASSERT(label, prop, msg)
`define UWMH_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/uwmh_pkg.sv =====
// ----------------------------------------------------------------------------
// Bootloader write-memory host package
// Shared types, protocol bytes and register map of the write-memory host.
// ----------------------------------------------------------------------------
package uwmh_pkg;

  // Bootloader protocol bytes.
  localparam logic [7:0] ACK_BYTE  = 8'h79;
  localparam logic [7:0] NACK_BYTE = 8'h1F;
  localparam logic [7:0] BUSY_BYTE = 8'h76;
  localparam logic [7:0] PAD_BYTE  = 8'hFF;
  localparam logic [1:0] ALIGN_MASK = 2'h3;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF     = 2;

  // Most results a single request can cause.
  localparam int MAX_RESULTS = 6;

  // Register map and reset values.
  localparam logic [2:0]  ADDR_WRITE_COMMAND  = 3'd0;
  localparam logic [2:0]  ADDR_TIMEOUT_TICKS  = 3'd4;
  localparam logic [7:0]  WRITE_COMMAND_RST   = 8'h31;
  localparam logic [31:0] TIMEOUT_TICKS_RST   = 32'd1000;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_REPLY = 2'd2,
    REQ_TICK  = 2'd3
  } req_e_t;

  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_OK         = 3'd1,
    ST_NACK       = 3'd2,
    ST_UNEXPECTED = 3'd3,
    ST_TIMEOUT    = 3'd4,
    ST_BAD        = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WAIT_CMD   = 3'd1,
    PH_WAIT_ADDR  = 3'd2,
    PH_DATA       = 3'd3,
    PH_WAIT_FINAL = 3'd4
  } phase_t;

  // One incoming request.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [8:0]  length;
    logic [7:0]  data_byte;
    logic [7:0]  reply_byte;
  } request_t;

  // One result.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic [2:0] status;
  } result_t;

  // Work for the back end: up to six results of one request.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [2:0]                  count;
    logic                        tx;
    status_t                     status;
  } desc_t;

endpackage

// ===== src/uwmh_front.sv =====
// ----------------------------------------------------------------------------
// Write-memory host front end
// Takes requests, runs the exchange state machine and queues result work.
// ----------------------------------------------------------------------------
module uwmh_front #(
  parameter int MAX_FRAME_BYTES = uwmh_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  uwmh_pkg::request_t request,
  input  logic [7:0]        write_command,
  input  logic [31:0]       timeout_ticks,
  output logic              q_push,
  output uwmh_pkg::desc_t   q_desc,
  input  logic              q_full
);

`include "uart_boot_write_memory_host_core_defines.svh"

  uwmh_pkg::phase_t phase, phase_next;
  logic [31:0] target_address, target_address_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [8:0]  padded_length, padded_length_next;
  logic [7:0]  running_checksum, running_checksum_next;
  logic        first_pending, first_pending_next;
  logic [31:0] wait_counter, wait_counter_next;

  logic        accept;
  logic        waiting;
  logic [2:0]  n;
  logic [7:0]  csum;
  logic [8:0]  pad_dec;
  logic [31:0] wait_inc;
  logic [7:0]  addr_xor;

  function automatic uwmh_pkg::desc_t status_desc(uwmh_pkg::status_t s);
    uwmh_pkg::desc_t d;
    d        = '0;
    d.count  = 3'd1;
    d.tx     = 1'b0;
    d.status = s;
    return d;
  endfunction

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign waiting = (phase == uwmh_pkg::PH_WAIT_CMD) || (phase == uwmh_pkg::PH_WAIT_ADDR) ||
                   (phase == uwmh_pkg::PH_WAIT_FINAL);
  assign pad_dec  = padded_length - 9'd1;
  assign wait_inc = wait_counter + 32'd1;
  assign addr_xor = target_address[31:24] ^ target_address[23:16] ^
                    target_address[15:8] ^ target_address[7:0];

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= uwmh_pkg::PH_IDLE;
      target_address   <= '0;
      bytes_left       <= '0;
      padded_length    <= '0;
      running_checksum <= '0;
      first_pending    <= 1'b0;
      wait_counter     <= '0;
    end else begin
      phase            <= phase_next;
      target_address   <= target_address_next;
      bytes_left       <= bytes_left_next;
      padded_length    <= padded_length_next;
      running_checksum <= running_checksum_next;
      first_pending    <= first_pending_next;
      wait_counter     <= wait_counter_next;
    end
  end

  // Next state and the result work of the accepted request.
  always_comb begin
    phase_next            = phase;
    target_address_next   = target_address;
    bytes_left_next       = bytes_left;
    padded_length_next    = padded_length;
    running_checksum_next = running_checksum;
    first_pending_next    = first_pending;
    wait_counter_next     = wait_counter;
    q_push                = 1'b0;
    q_desc                = '0;
    q_desc.status         = uwmh_pkg::ST_BUSY;
    n                     = 3'd0;
    csum                  = running_checksum;

    if (accept) begin
      unique case (uwmh_pkg::req_e_t'(request.req_type))
        uwmh_pkg::REQ_START: begin
          q_push = 1'b1;
          if (phase != uwmh_pkg::PH_IDLE) begin
            q_desc = status_desc(uwmh_pkg::ST_BAD);
          end else if (request.length == 9'd0) begin
            q_desc = status_desc(uwmh_pkg::ST_OK);
          end else if (request.length > 9'(MAX_FRAME_BYTES) ||
                       (request.address[1:0] & uwmh_pkg::ALIGN_MASK) != 2'd0) begin
            q_desc = status_desc(uwmh_pkg::ST_BAD);
          end else begin
            target_address_next = request.address;
            bytes_left_next     = request.length;
            padded_length_next  = (request.length + 9'd3) & ~9'd3;
            first_pending_next  = 1'b0;
            wait_counter_next   = '0;
            phase_next          = uwmh_pkg::PH_WAIT_CMD;
            q_desc.bytes[0]     = write_command;
            q_desc.bytes[1]     = write_command ^ uwmh_pkg::PAD_BYTE;
            q_desc.count        = 3'd2;
            q_desc.tx           = 1'b1;
          end
        end

        uwmh_pkg::REQ_DATA: begin
          q_push = 1'b1;
          if (phase != uwmh_pkg::PH_DATA || bytes_left == 9'd0 || padded_length == 9'd0) begin
            q_desc = status_desc(uwmh_pkg::ST_BAD);
          end else begin
            // The length byte leaves ahead of the first payload byte.
            if (first_pending) begin
              q_desc.bytes[n] = running_checksum;
              n = n + 3'd1;
            end
            csum = csum ^ request.data_byte;
            q_desc.bytes[n] = request.data_byte;
            n = n + 3'd1;
            bytes_left_next    = bytes_left - 9'd1;
            padded_length_next = pad_dec;
            first_pending_next = 1'b0;
            // Last payload byte: pad to a word and close with the checksum.
            if (bytes_left == 9'd1) begin
              for (int i = 0; i < 3; i++) begin
                if (9'(i) < pad_dec) begin
                  q_desc.bytes[n] = uwmh_pkg::PAD_BYTE;
                  n = n + 3'd1;
                  csum = csum ^ uwmh_pkg::PAD_BYTE;
                end
              end
              q_desc.bytes[n] = csum;
              n = n + 3'd1;
              padded_length_next = '0;
              wait_counter_next  = '0;
              phase_next         = uwmh_pkg::PH_WAIT_FINAL;
            end
            running_checksum_next = csum;
            q_desc.count = n;
            q_desc.tx    = 1'b1;
          end
        end

        uwmh_pkg::REQ_REPLY: begin
          if (waiting && request.reply_byte != uwmh_pkg::BUSY_BYTE) begin
            if (request.reply_byte == uwmh_pkg::NACK_BYTE) begin
              q_push     = 1'b1;
              q_desc     = status_desc(uwmh_pkg::ST_NACK);
              phase_next = uwmh_pkg::PH_IDLE;
            end else if (request.reply_byte != uwmh_pkg::ACK_BYTE) begin
              q_push     = 1'b1;
              q_desc     = status_desc(uwmh_pkg::ST_UNEXPECTED);
              phase_next = uwmh_pkg::PH_IDLE;
            end else if (phase == uwmh_pkg::PH_WAIT_CMD) begin
              // Address, most significant byte first, then its XOR.
              q_push            = 1'b1;
              q_desc.bytes[0]   = target_address[31:24];
              q_desc.bytes[1]   = target_address[23:16];
              q_desc.bytes[2]   = target_address[15:8];
              q_desc.bytes[3]   = target_address[7:0];
              q_desc.bytes[4]   = addr_xor;
              q_desc.count      = 3'd5;
              q_desc.tx         = 1'b1;
              wait_counter_next = '0;
              phase_next        = uwmh_pkg::PH_WAIT_ADDR;
            end else if (phase == uwmh_pkg::PH_WAIT_ADDR) begin
              running_checksum_next = pad_dec[7:0];
              first_pending_next    = 1'b1;
              phase_next            = uwmh_pkg::PH_DATA;
            end else begin
              q_push     = 1'b1;
              q_desc     = status_desc(uwmh_pkg::ST_OK);
              phase_next = uwmh_pkg::PH_IDLE;
            end
          end
        end

        uwmh_pkg::REQ_TICK: begin
          if (waiting) begin
            wait_counter_next = wait_inc;
            if (wait_inc >= timeout_ticks) begin
              q_push     = 1'b1;
              q_desc     = status_desc(uwmh_pkg::ST_TIMEOUT);
              phase_next = uwmh_pkg::PH_IDLE;
            end
          end
        end

        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  // The second acknowledge opens the payload phase with the length byte pending.
  `UWMH_ASSERT(a_second_ack_opens_data, (accept && request.req_type == uwmh_pkg::REQ_REPLY && request.reply_byte == uwmh_pkg::ACK_BYTE && phase == uwmh_pkg::PH_WAIT_ADDR) |=> (phase == uwmh_pkg::PH_DATA && first_pending), "second ack did not open the payload phase")
  // Queued work always holds at least one result and never overruns the queue.
  `UWMH_ASSERT(a_push_nonempty, q_push |-> (q_desc.count != 3'd0 && !q_full), "bad push into the work queue")

endmodule

// ===== src/uwmh_desc_fifo.sv =====
// ----------------------------------------------------------------------------
// Write-memory host work queue
// Small register queue between front end and back end.
// ----------------------------------------------------------------------------
module uwmh_desc_fifo #(
  parameter int DEPTH = uwmh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  uwmh_pkg::desc_t wr_data,
  output logic            full,
  output logic            valid,
  output uwmh_pkg::desc_t head,
  input  logic            rd_en
);

`include "uart_boot_write_memory_host_core_defines.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uwmh_pkg::desc_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // The fill count never exceeds the depth.
  `UWMH_ASSERT(a_count_bound, count <= CW'(DEPTH), "work queue count out of range")

endmodule

// ===== src/uwmh_back.sv =====
// ----------------------------------------------------------------------------
// Write-memory host back end
// Expands queued work into results via an output register, one per cycle if popped.
// ----------------------------------------------------------------------------
module uwmh_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  uwmh_pkg::desc_t   q_head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output uwmh_pkg::result_t result
);

`include "uart_boot_write_memory_host_core_defines.svh"

  logic [2:0]        idx;
  logic              out_valid;
  uwmh_pkg::result_t out_reg;
  logic              advance;
  logic              at_last;

  assign advance = q_valid && (!out_valid || pop);
  assign at_last = (idx == q_head.count - 3'd1);
  assign q_pop   = advance && at_last;
  assign empty   = !out_valid;
  assign result  = out_reg;

  // Result index within the head entry and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg.tx_byte  <= q_head.bytes[idx];
      out_reg.tx_valid <= q_head.tx;
      out_reg.last     <= at_last;
      out_reg.status   <= q_head.status;
    end
  end

  // The index stays inside the head entry.
  `UWMH_ASSERT(a_idx_in_entry, q_valid |-> (idx < q_head.count), "result index past entry")
  // A transmitted byte never carries a final status.
  `UWMH_ASSERT(a_tx_status_busy, (out_valid && out_reg.tx_valid) |-> (out_reg.status == uwmh_pkg::ST_BUSY), "transmit result with final status")
  // The index is back at the start when nothing is queued after reset.
  `UWMH_ASSERT_ALWAYS(a_idx_reset, $past(rst) |-> (idx == 3'd0), "index not cleared by reset")

endmodule

// ===== src/uart_boot_write_memory_host_core.sv =====
// ----------------------------------------------------------------------------
// Bootloader write-memory host core
// Host side of a serial bootloader write-memory exchange.
// ----------------------------------------------------------------------------
// A request is taken whenever the work queue (two entries by default) has
// room; the front end updates the exchange state at once and queues the
// bytes that the request causes. The back end delivers one result per cycle
// through its output register while results are popped. Results of a request:
// none for busy replies, ticks and the second acknowledge, one for a status,
// two for the command, five for the address and up to six for the last
// payload byte. The first result passes the work queue, then the output
// register. The user must write configuration over the APB port only while
// the core is idle; the core itself does not enforce this.
module uart_boot_write_memory_host_core #(
  parameter int MAX_FRAME_BYTES = uwmh_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = uwmh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  uwmh_pkg::request_t request,
  output logic              empty,
  input  logic              pop,
  output uwmh_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]      write_command;
  logic [31:0]     timeout_ticks;
  logic            cfg_write;
  logic            q_push;
  uwmh_pkg::desc_t q_desc;
  logic            q_full;
  logic            q_valid;
  uwmh_pkg::desc_t q_head;
  logic            q_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers, selected by word address.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_command <= uwmh_pkg::WRITE_COMMAND_RST;
      timeout_ticks <= uwmh_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        timeout_ticks <= pwdata;
      end else begin
        write_command <= pwdata[7:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr)
      uwmh_pkg::ADDR_WRITE_COMMAND: prdata = {24'd0, write_command};
      uwmh_pkg::ADDR_TIMEOUT_TICKS: prdata = timeout_ticks;
      default:                      prdata = '0;
    endcase
  end

  uwmh_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .request       (request),
    .write_command (write_command),
    .timeout_ticks (timeout_ticks),
    .q_push        (q_push),
    .q_desc        (q_desc),
    .q_full        (q_full)
  );

  uwmh_desc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_desc),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head),
    .rd_en   (q_pop)
  );

  uwmh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
